@@ sv/sqlw_pkg.sv @@
// shared types and constants for the wire packet deframer and classifier
package sqlw_pkg;

    localparam int LEN_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 64;
    localparam int KIND_W  = 4;
    localparam int STATE_W = 3;

    // packet kinds
    localparam logic [KIND_W-1:0] KIND_AUTH      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_COMMAND   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_HANDSHAKE = 4'd2;
    localparam logic [KIND_W-1:0] KIND_OK        = 4'd3;
    localparam logic [KIND_W-1:0] KIND_ERR       = 4'd4;
    localparam logic [KIND_W-1:0] KIND_RSET      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_FIELD     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_EOF       = 4'd7;
    localparam logic [KIND_W-1:0] KIND_ROW       = 4'd8;

    // protocol states
    localparam logic [STATE_W-1:0] ST_AWAIT_AUTH = 3'd0;
    localparam logic [STATE_W-1:0] ST_COMMANDS   = 3'd1;
    localparam logic [STATE_W-1:0] ST_AWAIT_HS   = 3'd2;
    localparam logic [STATE_W-1:0] ST_AFTER_HS   = 3'd3;
    localparam logic [STATE_W-1:0] ST_FIELDS     = 3'd4;
    localparam logic [STATE_W-1:0] ST_ROWS       = 3'd5;

    // marker bytes
    localparam logic [BYTE_W-1:0] MARK_OK      = 8'd0;
    localparam logic [BYTE_W-1:0] MARK_NULL    = 8'd251;
    localparam logic [BYTE_W-1:0] MARK_TWO     = 8'd252;
    localparam logic [BYTE_W-1:0] MARK_THREE   = 8'd253;
    localparam logic [BYTE_W-1:0] MARK_EIGHT   = 8'd254;
    localparam logic [BYTE_W-1:0] MARK_ERR     = 8'd255;
    localparam logic [BYTE_W-1:0] HS_VERSION   = 8'd10;
    localparam logic [LEN_W-1:0]  EOF_LEN_LIM  = 24'd6;

    // register indexes
    localparam logic REG_CONN_SIDE = 1'b0;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  seq;
        logic [BYTE_W-1:0]  first_byte;
        logic [COUNT_W-1:0] count;
    } desc_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  seq;
        logic [BYTE_W-1:0]  first_byte;
        logic [COUNT_W-1:0] count;
        logic               error;
        logic [STATE_W-1:0] state_after;
    } result_t;

endpackage

@@ sv/sql_wire_packet_deframe_classify.sv @@
// top level of the wire packet deframer and classifier
//
// s_ channel: one stream byte per transfer (s_data_byte), one connection
// direction. m_ channel: one transfer per completed packet with its kind,
// header length and sequence, first payload byte, decoded result-set
// column count, protocol error flag and protocol state after the packet.
// APB register 0 (conn_side) selects client or server stream; writing it
// restarts deframing and the protocol state machine.
// Throughput: one byte per cycle while the queue is not full. After a
// packet's last byte is taken, the deframer pushes a descriptor into a
// QUEUE_DEPTH entry queue, the classifier pops it into the result register.
// When m_ready is low the result register holds, the queue fills and
// s_ready drops only when the queue is full. After a bad handshake the
// block keeps taking bytes but gives no transfers until restarted.
// Reset (aresetn, synchronous) selects the client side and clears all
// framing and protocol state; no clearing pass is needed.
module sql_wire_packet_deframe_classify #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sqlw_pkg::BYTE_W-1:0]   s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sqlw_pkg::KIND_W-1:0]   m_packet_kind,
    output logic [sqlw_pkg::LEN_W-1:0]    m_payload_length,
    output logic [sqlw_pkg::BYTE_W-1:0]   m_sequence_id,
    output logic [sqlw_pkg::BYTE_W-1:0]   m_first_payload_byte,
    output logic [sqlw_pkg::COUNT_W-1:0]  m_column_count,
    output logic                          m_protocol_error,
    output logic [sqlw_pkg::STATE_W-1:0]  m_state_after,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic              side_reg;
    logic              wr_fire, restart, in_fire;
    logic              push, full, q_valid, q_pop;
    sqlw_pkg::desc_t   push_desc, q_desc;
    sqlw_pkg::result_t res;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite && pready;
    assign restart = wr_fire && (paddr[2] == sqlw_pkg::REG_CONN_SIDE);
    assign prdata  = (paddr[2] == sqlw_pkg::REG_CONN_SIDE) ? {31'd0, side_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= 1'b0;
        end else if (restart) begin
            side_reg <= pwdata[0];
        end
    end

    assign s_ready = !full;
    assign in_fire = s_valid && s_ready;

    sqlw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .in_fire   (in_fire),
        .data_byte (s_data_byte),
        .push      (push),
        .push_desc (push_desc)
    );

    sqlw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_desc  (q_desc)
    );

    sqlw_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .side_next (pwdata[0]),
        .q_valid   (q_valid),
        .q_desc    (q_desc),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    assign m_packet_kind        = res.kind;
    assign m_payload_length     = res.length;
    assign m_sequence_id        = res.seq;
    assign m_first_payload_byte = res.first_byte;
    assign m_column_count       = res.count;
    assign m_protocol_error     = res.error;
    assign m_state_after        = res.state_after;

endmodule

@@ sv/sqlw_front.sv @@
// byte deframer: header parse, payload count and length-encoded count decode
module sqlw_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  logic                        in_fire,
    input  logic [sqlw_pkg::BYTE_W-1:0] data_byte,
    output logic                        push,
    output sqlw_pkg::desc_t             push_desc
);

    localparam logic [2:0] HDR_LEN0 = 3'd0;
    localparam logic [2:0] HDR_LEN1 = 3'd1;
    localparam logic [2:0] HDR_LEN2 = 3'd2;
    localparam logic [2:0] HDR_SEQ  = 3'd3;
    localparam logic [2:0] HDR_PAY  = 3'd4;

    logic [2:0]                       hdr_reg, hdr_next;
    logic [sqlw_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [sqlw_pkg::BYTE_W-1:0]      seq_reg, seq_next;
    logic [sqlw_pkg::LEN_W-1:0]       pay_reg, pay_next;
    logic [sqlw_pkg::BYTE_W-1:0]      fb_reg, fb_next;
    logic [sqlw_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [3:0]                       left_reg, left_next;
    logic [2:0]                       lane;

    assign lane = pay_reg[2:0] - 3'd1;

    always_comb begin
        hdr_next  = hdr_reg;
        len_next  = len_reg;
        seq_next  = seq_reg;
        pay_next  = pay_reg;
        fb_next   = fb_reg;
        cnt_next  = cnt_reg;
        left_next = left_reg;
        push      = 1'b0;
        if (in_fire) begin
            case (hdr_reg)
                HDR_LEN0: begin
                    len_next = {16'd0, data_byte};
                    hdr_next = HDR_LEN1;
                end
                HDR_LEN1: begin
                    len_next[15:8] = data_byte;
                    hdr_next = HDR_LEN2;
                end
                HDR_LEN2: begin
                    len_next[23:16] = data_byte;
                    hdr_next = HDR_SEQ;
                end
                HDR_SEQ: begin
                    seq_next  = data_byte;
                    pay_next  = '0;
                    fb_next   = '0;
                    cnt_next  = '0;
                    left_next = '0;
                    if (len_reg == '0) begin
                        push     = 1'b1;
                        hdr_next = HDR_LEN0;
                    end else begin
                        hdr_next = HDR_PAY;
                    end
                end
                default: begin
                    if (pay_reg == '0) begin
                        fb_next = data_byte;
                        if (data_byte != sqlw_pkg::MARK_OK && data_byte != sqlw_pkg::MARK_ERR) begin
                            if (data_byte < sqlw_pkg::MARK_NULL) begin
                                cnt_next = {56'd0, data_byte};
                            end else if (data_byte == sqlw_pkg::MARK_NULL) begin
                                cnt_next = '1;
                            end else if (data_byte == sqlw_pkg::MARK_TWO) begin
                                left_next = 4'd2;
                            end else if (data_byte == sqlw_pkg::MARK_THREE) begin
                                left_next = 4'd3;
                            end else begin
                                left_next = 4'd8;
                            end
                        end
                    end else if (left_reg != '0) begin
                        for (int i = 0; i < 8; i++) begin
                            if (lane == 3'(i)) begin
                                cnt_next[i*8 +: 8] = cnt_reg[i*8 +: 8] | data_byte;
                            end
                        end
                        left_next = left_reg - 4'd1;
                    end
                    pay_next = pay_reg + 24'd1;
                    if (pay_next == len_reg) begin
                        push     = 1'b1;
                        hdr_next = HDR_LEN0;
                    end
                end
            endcase
        end
    end

    assign push_desc.length     = len_reg;
    assign push_desc.seq        = seq_next;
    assign push_desc.first_byte = fb_next;
    assign push_desc.count      = cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            hdr_reg  <= HDR_LEN0;
            len_reg  <= '0;
            seq_reg  <= '0;
            pay_reg  <= '0;
            fb_reg   <= '0;
            cnt_reg  <= '0;
            left_reg <= '0;
        end else begin
            hdr_reg  <= hdr_next;
            len_reg  <= len_next;
            seq_reg  <= seq_next;
            pay_reg  <= pay_next;
            fb_reg   <= fb_next;
            cnt_reg  <= cnt_next;
            left_reg <= left_next;
        end
    end

endmodule

@@ sv/sqlw_queue.sv @@
// packet descriptor queue between deframer and classifier
module sqlw_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            restart,
    input  logic            push,
    input  sqlw_pkg::desc_t push_desc,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output sqlw_pkg::desc_t pop_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    sqlw_pkg::desc_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_desc  = mem[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ sv/sqlw_back.sv @@
// protocol state machine, packet classification and result register
module sqlw_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic              side_next,
    input  logic              q_valid,
    input  sqlw_pkg::desc_t   q_desc,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output sqlw_pkg::result_t out_res
);

    logic [sqlw_pkg::STATE_W-1:0] state_reg, state_next;
    logic                         halted_reg, halted_next;
    logic                         valid_reg, valid_next;
    sqlw_pkg::result_t            res_reg, res_next;
    logic                         take, is_eof;
    logic [sqlw_pkg::BYTE_W-1:0]  fb;

    assign q_pop  = q_valid && (halted_reg || !valid_reg || out_ready);
    assign take   = q_pop && !halted_reg;
    assign fb     = q_desc.first_byte;
    assign is_eof = (fb == sqlw_pkg::MARK_EIGHT) && (q_desc.length < sqlw_pkg::EOF_LEN_LIM);

    always_comb begin
        state_next  = state_reg;
        halted_next = halted_reg;
        res_next    = res_reg;
        valid_next  = valid_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (take) begin
            res_next.kind       = sqlw_pkg::KIND_ROW;
            res_next.length     = q_desc.length;
            res_next.seq        = q_desc.seq;
            res_next.first_byte = fb;
            res_next.count      = '0;
            res_next.error      = 1'b0;
            case (state_reg)
                sqlw_pkg::ST_AWAIT_AUTH: begin
                    res_next.kind = sqlw_pkg::KIND_AUTH;
                    state_next    = sqlw_pkg::ST_COMMANDS;
                end
                sqlw_pkg::ST_COMMANDS: begin
                    res_next.kind = sqlw_pkg::KIND_COMMAND;
                end
                sqlw_pkg::ST_AWAIT_HS: begin
                    res_next.kind = sqlw_pkg::KIND_HANDSHAKE;
                    if (fb != sqlw_pkg::HS_VERSION) begin
                        res_next.error = 1'b1;
                        halted_next    = 1'b1;
                    end else begin
                        state_next = sqlw_pkg::ST_AFTER_HS;
                    end
                end
                sqlw_pkg::ST_AFTER_HS: begin
                    if (fb == sqlw_pkg::MARK_OK) begin
                        res_next.kind = sqlw_pkg::KIND_OK;
                    end else if (fb == sqlw_pkg::MARK_ERR) begin
                        res_next.kind = sqlw_pkg::KIND_ERR;
                    end else begin
                        res_next.kind  = sqlw_pkg::KIND_RSET;
                        res_next.count = q_desc.count;
                        state_next     = sqlw_pkg::ST_FIELDS;
                    end
                end
                sqlw_pkg::ST_FIELDS: begin
                    if (is_eof) begin
                        res_next.kind = sqlw_pkg::KIND_EOF;
                        state_next    = sqlw_pkg::ST_ROWS;
                    end else begin
                        res_next.kind = sqlw_pkg::KIND_FIELD;
                    end
                end
                sqlw_pkg::ST_ROWS: begin
                    if (is_eof) begin
                        res_next.kind = sqlw_pkg::KIND_EOF;
                        state_next    = sqlw_pkg::ST_AFTER_HS;
                    end else begin
                        res_next.kind = sqlw_pkg::KIND_ROW;
                    end
                end
                default: begin
                    res_next.kind = sqlw_pkg::KIND_ROW;
                end
            endcase
            res_next.state_after = state_next;
            valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sqlw_pkg::ST_AWAIT_AUTH;
            halted_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else if (restart) begin
            state_reg  <= side_next ? sqlw_pkg::ST_AWAIT_HS : sqlw_pkg::ST_AWAIT_AUTH;
            halted_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            halted_reg <= halted_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

@@ sv/sqlw_checker.sv @@
// port-level checker for the wire packet deframer and classifier, with bind
module sqlw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [sqlw_pkg::KIND_W-1:0]   m_packet_kind,
    input logic [sqlw_pkg::LEN_W-1:0]    m_payload_length,
    input logic [sqlw_pkg::COUNT_W-1:0]  m_column_count,
    input logic                          m_protocol_error,
    input logic [sqlw_pkg::STATE_W-1:0]  m_state_after
);

    // stalled transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_packet_kind)
            && $stable(m_payload_length) && $stable(m_column_count))
        else $error("stalled result changed");

    // error only on a handshake, which leaves the state awaiting handshake
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_protocol_error |->
            m_packet_kind == sqlw_pkg::KIND_HANDSHAKE
            && m_state_after == sqlw_pkg::ST_AWAIT_HS)
        else $error("protocol error on wrong packet");

    // column count only for result-set headers
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_kind != sqlw_pkg::KIND_RSET |-> m_column_count == '0)
        else $error("column count on non header");

    // header and eof transitions
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_kind == sqlw_pkg::KIND_RSET |->
            m_state_after == sqlw_pkg::ST_FIELDS)
        else $error("header did not enter fields");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_packet_kind == sqlw_pkg::KIND_EOF |->
            m_payload_length < sqlw_pkg::EOF_LEN_LIM
            && (m_state_after == sqlw_pkg::ST_ROWS
                || m_state_after == sqlw_pkg::ST_AFTER_HS))
        else $error("bad eof result");

endmodule

bind sql_wire_packet_deframe_classify sqlw_checker u_sqlw_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_packet_kind    (m_packet_kind),
    .m_payload_length (m_payload_length),
    .m_column_count   (m_column_count),
    .m_protocol_error (m_protocol_error),
    .m_state_after    (m_state_after)
);
